### src/afp_pkg.sv
// Shared types and constants of the adaptive frame pacer.
package afp_pkg;

  typedef enum logic [1:0] {
    ADJ_NONE  = 2'd0,
    ADJ_LOWER = 2'd1,
    ADJ_RAISE = 2'd2
  } adjust_t;

  // Configuration register indexes.
  localparam logic [2:0] CFG_ADAPT_ENABLE    = 3'd0;
  localparam logic [2:0] CFG_ADAPT_FACTOR    = 3'd1;
  localparam logic [2:0] CFG_INITIAL_TARGET  = 3'd2;
  localparam logic [2:0] CFG_MIN_INTERVAL_MS = 3'd3;
  localparam logic [2:0] CFG_MAX_TARGET      = 3'd4;

  // Configuration reset values.
  localparam logic        RST_ADAPT_ENABLE    = 1'b1;
  localparam logic [15:0] RST_ADAPT_FACTOR    = 16'd6554;
  localparam logic [15:0] RST_INITIAL_TARGET  = 16'd7680;
  localparam logic [15:0] RST_MIN_INTERVAL_MS = 16'd2000;
  localparam logic [15:0] RST_MAX_TARGET      = 16'd15360;

  // Rates in Q8.8 frames per second.
  localparam logic [15:0] Q_45FPS = 16'd11520;
  localparam logic [15:0] Q_30FPS = 16'd7680;

  // Drop-rate thresholds: 10% and 2% of frames, scaled for Q8.8 and ms.
  localparam logic [23:0] HIGH_DROP_MUL = 24'd2560000;
  localparam logic [23:0] LOW_DROP_MUL  = 24'd12800000;

  // Small factors for the rate comparisons.
  localparam logic [23:0] GOOD_FPS_MUL    = 24'd20;
  localparam logic [23:0] GOOD_TARGET_MUL = 24'd19;
  localparam logic [23:0] THR_MEAS_MUL    = 24'd5;
  localparam logic [23:0] THR_TARGET_MUL  = 24'd6;

  // Half frame time: 500 ms * 256 over a Q8.8 rate.
  localparam logic [22:0] TIMEOUT_NUM = 23'd128000;
  localparam logic [5:0]  TIMEOUT_MAX = 6'd33;

  localparam logic [2:0] DEPTH_FAST = 3'd2;
  localparam logic [2:0] DEPTH_MID  = 3'd3;
  localparam logic [2:0] DEPTH_SLOW = 3'd4;

endpackage

### src/adaptive_frame_pacer_core.sv
// Adaptive frame pacer: sequencer around one shared 32x24 multiplier.
//
// Input beats arrive on the s_axis channel; tuser carries the operation
// (0 restart, 1 update) and tdata the time stamp, measured rate and drop
// total. Every input beat yields exactly one result beat on m_axis with the
// target rate, adjust code, queue depth, throttle flag and timeout.
// Configuration writes use the cfg channel, which is always ready; the user
// must make them only while the block is idle, which the block does not enforce.
//
// From input acceptance to the result load, a restart or a skipped update goes
// from S_CHECK straight to the throttle steps; an update that keeps the target
// also passes S_D through S_ADJ, and a full adaptation adds S_STEP and S_APPLY.
// All products go through one multiplier with a registered output, read in the
// state after the one that sets the operands; the timeout quotient is found bit
// by bit over six multiply and compare rounds. s_axis_tready is high only between
// items, so the next item is taken only once the previous result is loaded. The
// result sits in an output register, so a new item is accepted while the previous
// result still waits; if the receiver stalls, the next result holds in the last
// sequencer step until the register frees up. Reset (rst, synchronous) restores
// the register defaults and the pacer state to 30 fps with zero drop total and time stamp.
module adaptive_frame_pacer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // time_ms[31:0], render_fps[47:32], drop_total[79:48]
  input  logic [0:0]  s_axis_tuser,  // operation[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // target_rate[15:0], adjust[17:16], queue_depth[20:18],
                                     // throttle[21], timeout_ms[27:22], zero[31:28]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_D,
    S_H,
    S_L,
    S_G,
    S_G2,
    S_ADJ,
    S_STEP,
    S_APPLY,
    S_THR,
    S_THR2,
    S_THR3,
    S_TO_MUL,
    S_TO_CMP,
    S_OUT
  } state_t;

  state_t state;

  // Configuration registers.
  logic        adapt_enable;
  logic [15:0] adapt_factor;
  logic [15:0] initial_target;
  logic [15:0] min_interval_ms;
  logic [15:0] max_target;

  // Pacer state.
  logic [15:0] target_reg;
  logic [15:0] measured_reg;
  logic [31:0] last_drops;
  logic [31:0] last_time;

  // Item registers.
  logic        in_op;
  logic [31:0] in_time;
  logic [15:0] in_fps;
  logic [31:0] in_drops;
  logic [31:0] elapsed;
  logic [31:0] delta;
  logic [47:0] d_reg;
  logic        high;
  logic        low;
  logic [20:0] fps20;
  afp_pkg::adjust_t adjust;
  logic [18:0] m5;
  logic        throttle;
  logic [5:0]  qacc;
  logic [2:0]  bit_idx;

  // Shared multiplier.
  logic [31:0] mul_a;
  logic [23:0] mul_b;
  logic [55:0] mul_p;
  logic [55:0] prod;

  logic [31:0] elapsed_c;
  logic [5:0]  cand;
  logic [16:0] raised;
  logic [15:0] stepped;
  logic [15:0] stepped_next;
  logic [2:0]  depth;

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;

  assign elapsed_c = in_time - last_time;
  assign cand      = qacc | (6'd1 << bit_idx);
  assign mul_p     = mul_a * mul_b;

  always_comb begin
    mul_a = {16'd0, target_reg};
    mul_b = 24'd0;
    unique case (state)
      S_D: begin
        mul_a = elapsed;
        mul_b = {8'd0, in_fps};
      end
      S_H: begin
        mul_a = delta;
        mul_b = afp_pkg::HIGH_DROP_MUL;
      end
      S_L: begin
        mul_a = delta;
        mul_b = afp_pkg::LOW_DROP_MUL;
      end
      S_G: begin
        mul_a = {16'd0, in_fps};
        mul_b = afp_pkg::GOOD_FPS_MUL;
      end
      S_G2: mul_b = afp_pkg::GOOD_TARGET_MUL;
      S_STEP: begin
        if (adjust == afp_pkg::ADJ_LOWER) begin
          mul_b = {7'd0, 17'h10000 - {1'b0, adapt_factor}};
        end else begin
          mul_b = {6'd0, 18'h20000 + {2'b0, adapt_factor}};
        end
      end
      S_THR: begin
        mul_a = {16'd0, measured_reg};
        mul_b = afp_pkg::THR_MEAS_MUL;
      end
      S_THR2: mul_b = afp_pkg::THR_TARGET_MUL;
      S_TO_MUL: mul_b = {18'd0, cand};
      default: mul_b = 24'd0;
    endcase
  end

  // New target after a lowering or raising step, capped and floored.
  always_comb begin
    raised = prod[33:17];
    if (adjust == afp_pkg::ADJ_LOWER) begin
      stepped = prod[31:16];
    end else if (raised > {1'b0, max_target}) begin
      stepped = max_target;
    end else begin
      stepped = raised[15:0];
    end
    stepped_next = (stepped == 16'd0) ? 16'd1 : stepped;
  end

  always_comb begin
    if (target_reg >= afp_pkg::Q_45FPS) begin
      depth = afp_pkg::DEPTH_FAST;
    end else if (target_reg >= afp_pkg::Q_30FPS) begin
      depth = afp_pkg::DEPTH_MID;
    end else begin
      depth = afp_pkg::DEPTH_SLOW;
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_p;
    if (rst) begin
      state           <= S_IDLE;
      m_axis_tvalid   <= 1'b0;
      adapt_enable    <= afp_pkg::RST_ADAPT_ENABLE;
      adapt_factor    <= afp_pkg::RST_ADAPT_FACTOR;
      initial_target  <= afp_pkg::RST_INITIAL_TARGET;
      min_interval_ms <= afp_pkg::RST_MIN_INTERVAL_MS;
      max_target      <= afp_pkg::RST_MAX_TARGET;
      target_reg      <= afp_pkg::Q_30FPS;
      measured_reg    <= afp_pkg::Q_30FPS;
      last_drops      <= 32'd0;
      last_time       <= 32'd0;
      adjust          <= afp_pkg::ADJ_NONE;
      qacc            <= 6'd0;
      bit_idx         <= 3'd0;
    end else begin
      // In the last step the result load below decides the valid flag.
      if (m_axis_tvalid && m_axis_tready && (state != S_OUT)) begin
        m_axis_tvalid <= 1'b0;
      end

      if (cfg_valid) begin
        unique case (cfg_index)
          afp_pkg::CFG_ADAPT_ENABLE:    adapt_enable    <= cfg_data[0];
          afp_pkg::CFG_ADAPT_FACTOR:    adapt_factor    <= cfg_data;
          afp_pkg::CFG_INITIAL_TARGET:  initial_target  <= cfg_data;
          afp_pkg::CFG_MIN_INTERVAL_MS: min_interval_ms <= cfg_data;
          afp_pkg::CFG_MAX_TARGET:      max_target      <= cfg_data;
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            in_op    <= s_axis_tuser[0];
            in_time  <= s_axis_tdata[31:0];
            in_fps   <= s_axis_tdata[47:32];
            in_drops <= s_axis_tdata[79:48];
            state    <= S_CHECK;
          end
        end
        S_CHECK: begin
          adjust  <= afp_pkg::ADJ_NONE;
          elapsed <= elapsed_c;
          delta   <= in_drops - last_drops;
          if (!in_op) begin
            target_reg   <= (initial_target == 16'd0) ? 16'd1 : initial_target;
            measured_reg <= initial_target;
            last_drops   <= in_drops;
            last_time    <= in_time;
            state        <= S_THR;
          end else if (adapt_enable && (elapsed_c >= {16'd0, min_interval_ms})) begin
            measured_reg <= in_fps;
            last_drops   <= in_drops;
            last_time    <= in_time;
            state        <= S_D;
          end else begin
            state <= S_THR;
          end
        end
        S_D: state <= S_H;
        S_H: begin
          d_reg <= prod[47:0];
          state <= S_L;
        end
        S_L: begin
          high  <= (prod > {8'd0, d_reg});
          state <= S_G;
        end
        S_G: begin
          low   <= (prod < {8'd0, d_reg});
          state <= S_G2;
        end
        S_G2: begin
          fps20 <= prod[20:0];
          state <= S_ADJ;
        end
        S_ADJ: begin
          if (high) begin
            adjust <= afp_pkg::ADJ_LOWER;
            state  <= S_STEP;
          end else if (low && (fps20 >= prod[20:0])) begin
            adjust <= afp_pkg::ADJ_RAISE;
            state  <= S_STEP;
          end else begin
            state <= S_THR;
          end
        end
        S_STEP: state <= S_APPLY;
        S_APPLY: begin
          target_reg <= stepped_next;
          state      <= S_THR;
        end
        S_THR: state <= S_THR2;
        S_THR2: begin
          m5    <= prod[18:0];
          state <= S_THR3;
        end
        S_THR3: begin
          throttle <= (m5 > prod[18:0]);
          qacc     <= 6'd0;
          bit_idx  <= 3'd5;
          state    <= S_TO_MUL;
        end
        S_TO_MUL: state <= S_TO_CMP;
        S_TO_CMP: begin
          // Keep the trial bit while the quotient stays within the clamp.
          if ((cand <= afp_pkg::TIMEOUT_MAX) && (prod[22:0] <= afp_pkg::TIMEOUT_NUM)) begin
            qacc <= cand;
          end
          if (bit_idx == 3'd0) begin
            state <= S_OUT;
          end else begin
            bit_idx <= bit_idx - 3'd1;
            state   <= S_TO_MUL;
          end
        end
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= {4'd0, qacc, throttle, depth, adjust, target_reg};
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_target_nonzero: assert property (@(posedge clk) disable iff (rst)
    target_reg != 16'd0)
    else $error("target rate reached zero");

  a_timeout_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[27:22] >= 6'd1) && (m_axis_tdata[27:22] <= 6'd33))
    else $error("timeout outside 1 to 33");

  a_quotient_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_TO_CMP) |=> (qacc <= afp_pkg::TIMEOUT_MAX))
    else $error("timeout quotient exceeded clamp");

  a_depth_tracks_target: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) && (!m_axis_tvalid || m_axis_tready) |=>
      ((m_axis_tdata[20:18] == afp_pkg::DEPTH_FAST) == (m_axis_tdata[15:0] >= afp_pkg::Q_45FPS)))
    else $error("queue depth does not match target rate");

endmodule

### test/tb.sv
// Self-checking testbench for the adaptive frame pacer core.
`timescale 1ns / 100ps

module tb;

  localparam logic OP_RESTART = 1'b0;
  localparam logic OP_UPDATE  = 1'b1;
  // Index with no register behind it; writes to it must change nothing.
  localparam logic [2:0] CFG_UNUSED = 3'd7;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 500;
  localparam int PHASE_ITEMS    = 220;

  typedef struct packed {
    logic        op;
    logic [31:0] time_ms;
    logic [15:0] render_fps;
    logic [31:0] drop_total;
  } frame_stat_t;

  typedef struct packed {
    logic [15:0] target_rate;
    logic [1:0]  adjust;
    logic [2:0]  queue_depth;
    logic        throttle;
    logic [5:0]  timeout_ms;
  } pace_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;  // time_ms[31:0], render_fps[47:32], drop_total[79:48]
  logic [0:0]  s_axis_tuser = '0;  // operation[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;       // target_rate[15:0], adjust[17:16], queue_depth[20:18],
                                   // throttle[21], timeout_ms[27:22], zero[31:28]
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  adaptive_frame_pacer_core DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Pacer state and settings as the block should hold them.
  logic        pm_enable;
  logic [15:0] pm_factor;
  logic [15:0] pm_initial;
  logic [15:0] pm_min_interval;
  logic [15:0] pm_max;
  logic [15:0] pm_target;
  logic [15:0] pm_measured;
  logic [31:0] pm_drops;
  logic [31:0] pm_time;

  frame_stat_t  frame_stats_q[$];
  pace_result_t pending_results[$];

  logic in_fire  = 1'b0;
  logic cfg_fire = 1'b0;
  int   mismatches = 0;
  int   quiet = 0;

  // Controls shared by the sequence and the two drivers.
  int   idle_odds = 8;
  logic no_idle = 1'b0;
  logic long_hold_req = 1'b0;
  logic long_hold_taken = 1'b0;
  int   hold_left = 0;
  int   sink_stall = 0;
  int   src_gap = 0;

  // Stimulus-side notion of time and drop count, used to build sane sequences.
  logic [31:0] g_time = '0;
  logic [31:0] g_drops = '0;
  logic [15:0] g_min = afp_pkg::RST_MIN_INTERVAL_MS;

  function automatic pace_result_t pace_step(frame_stat_t s);
    pace_result_t r;
    logic [31:0]  elapsed;
    logic [31:0]  quot;
    logic [63:0]  span;
    logic [63:0]  lost;
    logic [63:0]  fps64;
    logic [63:0]  prod;
    logic [15:0]  t;
    r.adjust = afp_pkg::ADJ_NONE;
    if (s.op == OP_RESTART) begin
      pm_target   = (pm_initial != 16'd0) ? pm_initial : 16'd1;
      pm_measured = pm_initial;
      pm_drops    = s.drop_total;
      pm_time     = s.time_ms;
    end else if (pm_enable) begin
      elapsed = s.time_ms - pm_time;
      if (elapsed >= {16'd0, pm_min_interval}) begin
        lost        = {32'd0, s.drop_total - pm_drops};
        fps64       = {48'd0, s.render_fps};
        span        = fps64 * {32'd0, elapsed};
        pm_measured = s.render_fps;
        pm_drops    = s.drop_total;
        pm_time     = s.time_ms;
        if (lost * {40'd0, afp_pkg::HIGH_DROP_MUL} > span) begin
          prod = ({48'd0, pm_target} * (64'd65536 - {48'd0, pm_factor})) >> 16;
          pm_target = (prod != 64'd0) ? prod[15:0] : 16'd1;
          r.adjust = afp_pkg::ADJ_LOWER;
        end else if (lost * {40'd0, afp_pkg::LOW_DROP_MUL} < span &&
                     fps64 * {40'd0, afp_pkg::GOOD_FPS_MUL} >=
                     {48'd0, pm_target} * {40'd0, afp_pkg::GOOD_TARGET_MUL}) begin
          prod = ({48'd0, pm_target} * (64'd131072 + {48'd0, pm_factor})) >> 17;
          if (prod > {48'd0, pm_max}) prod = {48'd0, pm_max};
          pm_target = (prod != 64'd0) ? prod[15:0] : 16'd1;
          r.adjust = afp_pkg::ADJ_RAISE;
        end
      end
    end
    t = (pm_target != 16'd0) ? pm_target : 16'd1;
    r.target_rate = t;
    r.queue_depth = (t >= afp_pkg::Q_45FPS) ? afp_pkg::DEPTH_FAST :
                    (t >= afp_pkg::Q_30FPS) ? afp_pkg::DEPTH_MID : afp_pkg::DEPTH_SLOW;
    r.throttle = ({48'd0, pm_measured} * {40'd0, afp_pkg::THR_MEAS_MUL} >
                  {48'd0, t} * {40'd0, afp_pkg::THR_TARGET_MUL});
    quot = {9'd0, afp_pkg::TIMEOUT_NUM} / {16'd0, t};
    if (quot < 32'd1) quot = 32'd1;
    if (quot > {26'd0, afp_pkg::TIMEOUT_MAX}) quot = {26'd0, afp_pkg::TIMEOUT_MAX};
    r.timeout_ms = quot[5:0];
    return r;
  endfunction

  function automatic string show(pace_result_t r);
    return $sformatf("rate %0d adjust %0d depth %0d throttle %0d timeout %0d",
                     r.target_rate, r.adjust, r.queue_depth, r.throttle, r.timeout_ms);
  endfunction

  // Predictor and checker: everything is sampled at the rising edge.
  always @(posedge clk) begin
    pace_result_t got;
    pace_result_t want;
    in_fire  <= s_axis_tvalid && s_axis_tready;
    cfg_fire <= cfg_valid && cfg_ready;
    if (rst) begin
      pm_enable       = afp_pkg::RST_ADAPT_ENABLE;
      pm_factor       = afp_pkg::RST_ADAPT_FACTOR;
      pm_initial      = afp_pkg::RST_INITIAL_TARGET;
      pm_min_interval = afp_pkg::RST_MIN_INTERVAL_MS;
      pm_max          = afp_pkg::RST_MAX_TARGET;
      pm_target       = afp_pkg::Q_30FPS;
      pm_measured     = afp_pkg::Q_30FPS;
      pm_drops        = '0;
      pm_time         = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          afp_pkg::CFG_ADAPT_ENABLE:    pm_enable = cfg_data[0];
          afp_pkg::CFG_ADAPT_FACTOR:    pm_factor = cfg_data;
          afp_pkg::CFG_INITIAL_TARGET:  pm_initial = cfg_data;
          afp_pkg::CFG_MIN_INTERVAL_MS: pm_min_interval = cfg_data;
          afp_pkg::CFG_MAX_TARGET:      pm_max = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        pending_results.push_back(pace_step({s_axis_tuser[0], s_axis_tdata[31:0],
                                             s_axis_tdata[47:32], s_axis_tdata[79:48]}));
      if (m_axis_tvalid && m_axis_tready) begin
        got.target_rate = m_axis_tdata[15:0];
        got.adjust      = m_axis_tdata[17:16];
        got.queue_depth = m_axis_tdata[20:18];
        got.throttle    = m_axis_tdata[21];
        got.timeout_ms  = m_axis_tdata[27:22];
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result beat with nothing pending: %s", $time, show(got));
        end else begin
          want = pending_results.pop_front();
          if (got.target_rate !== want.target_rate || got.adjust !== want.adjust ||
              got.queue_depth !== want.queue_depth || got.throttle !== want.throttle ||
              got.timeout_ms !== want.timeout_ms || m_axis_tdata[31:28] !== 4'd0) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: expected %s, got %s pad %h", $time, show(want), show(got),
                       m_axis_tdata[31:28]);
          end
        end
      end
    end
  end

  // Input driver: holds each beat until it is taken, with random gaps between beats.
  always @(negedge clk) begin
    frame_stat_t fs;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !in_fire) begin
      // Beat still waiting for tready.
    end else if (src_gap != 0) begin
      src_gap--;
      s_axis_tvalid <= 1'b0;
    end else if (frame_stats_q.size() != 0) begin
      fs = frame_stats_q.pop_front();
      s_axis_tdata  <= {fs.drop_total, fs.render_fps, fs.time_ms};
      s_axis_tuser  <= fs.op;
      s_axis_tvalid <= 1'b1;
      if (!no_idle && $urandom_range(0, idle_odds - 1) == 0) src_gap = $urandom_range(1, 15);
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // Result receiver: random stall bursts plus one long hold-off on request.
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (long_hold_req && !long_hold_taken) begin
      long_hold_taken = 1'b1;
      hold_left = LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (sink_stall != 0) begin
      sink_stall--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (!no_idle && $urandom_range(0, idle_odds - 1) == 0) sink_stall = $urandom_range(1, 15);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic queue_item(logic op, logic [31:0] t_ms, logic [15:0] fps, logic [31:0] drops);
    frame_stat_t fs;
    fs.op         = op;
    fs.time_ms    = t_ms;
    fs.render_fps = fps;
    fs.drop_total = drops;
    frame_stats_q.push_back(fs);
  endtask

  task automatic queue_restart;
    if ($urandom_range(0, 3) == 0) begin
      g_time  = $urandom();
      g_drops = $urandom();
    end else begin
      g_time  += $urandom_range(0, 5000);
      g_drops += $urandom_range(0, 50);
    end
    queue_item(OP_RESTART, g_time, 16'($urandom_range(0, 65535)), g_drops);
  endtask

  task automatic queue_update;
    int          pick;
    logic [15:0] fps;
    if ($urandom_range(0, 99) < 3) begin
      // Broken sequence: time and drop count jump anywhere.
      g_time  = $urandom();
      g_drops = $urandom();
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 70)      g_time += g_min + $urandom_range(0, 3000);
      else if (pick < 82) g_time += $urandom_range(0, g_min);
      else if (pick < 88) g_time += 0;
      else                g_time += $urandom();
      pick = $urandom_range(0, 99);
      if (pick < 35)      g_drops += 0;
      else if (pick < 60) g_drops += $urandom_range(1, 4);
      else if (pick < 85) g_drops += $urandom_range(5, 40);
      else if (pick < 95) g_drops += $urandom_range(0, 1000);
      else                g_drops += $urandom();
    end
    pick = $urandom_range(0, 99);
    if (pick < 60)      fps = 16'($urandom_range(6000, 16000));
    else if (pick < 80) fps = 16'($urandom_range(0, 65535));
    else if (pick < 85) fps = 16'd0;
    else if (pick < 90) fps = 16'hFFFF;
    else                fps = 16'($urandom_range(1, 3000));
    queue_item(OP_UPDATE, g_time, fps, g_drops);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(negedge clk); while (!cfg_fire);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(logic en, logic [15:0] factor, logic [15:0] init_rate,
                            logic [15:0] min_ms, logic [15:0] max_rate);
    write_reg(afp_pkg::CFG_ADAPT_ENABLE, {15'd0, en});
    write_reg(afp_pkg::CFG_ADAPT_FACTOR, factor);
    write_reg(afp_pkg::CFG_INITIAL_TARGET, init_rate);
    write_reg(afp_pkg::CFG_MIN_INTERVAL_MS, min_ms);
    write_reg(afp_pkg::CFG_MAX_TARGET, max_rate);
    g_min = min_ms;
  endtask

  // Waits until every queued item has gone in and every result has come out.
  // The check runs at the rising edge, where the driver's last update has settled.
  task automatic wait_drained;
    do @(posedge clk);
    while (frame_stats_q.size() != 0 || s_axis_tvalid || pending_results.size() != 0);
  endtask

  task automatic run_phase(int n, int pause_at);
    queue_restart();
    for (int k = 1; k < n; k++) begin
      if (k == pause_at) wait_drained();
      if ($urandom_range(0, 99) < 6) queue_restart();
      else queue_update();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed items under the reset settings.
    queue_item(OP_UPDATE, 32'd0, 16'd7680, 32'd0);      // zero elapsed, too soon
    queue_item(OP_UPDATE, 32'd2000, 16'd7680, 32'd0);   // exactly the interval, no drops
    queue_item(OP_UPDATE, 32'd4000, 16'd7680, 32'd100); // heavy drops
    queue_item(OP_UPDATE, 32'd5999, 16'd7680, 32'd100); // one ms short
    queue_item(OP_UPDATE, 32'd6000, 16'd0, 32'd100);    // zero rate, no drops
    queue_item(OP_UPDATE, 32'd8000, 16'd0, 32'd101);    // zero rate, one drop
    queue_item(OP_UPDATE, 32'd10000, 16'd7680, 32'd104); // between the two drop bands
    queue_item(OP_UPDATE, 32'd12000, 16'd7000, 32'd104);
    queue_item(OP_RESTART, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    // Time and drop count wrap; then keep raising until the cap bites.
    for (int k = 0; k < 16; k++)
      queue_item(OP_UPDATE, 32'h0000_07CF + 32'd2000 * k, 16'hFFFF, 32'd0);
    g_time  = 32'h0000_07CF + 32'd2000 * 15;
    g_drops = 32'd0;
    wait_drained();

    for (int ph = 1; ph <= 7; ph++) begin
      case (ph)
        1: begin
          idle_odds = 4;
          set_config(1'b1, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
          // With no least interval, updates at the same time stamp still adapt.
          queue_item(OP_RESTART, g_time, 16'd7680, g_drops);
          queue_item(OP_UPDATE, g_time, 16'd7680, g_drops);
          queue_item(OP_UPDATE, g_time, 16'd7680, g_drops + 32'd1);
          g_drops += 32'd1;
        end
        2: begin
          idle_odds = 16;
          set_config(1'b0, 16'd0, 16'd1, 16'hFFFF, 16'd1);
        end
        3: begin
          idle_odds = 8;
          set_config(1'b1, 16'd0, 16'd0, 16'd1, 16'd0);
          long_hold_req = 1'b1;
        end
        4: begin
          idle_odds = 64;
          // Restart loads a target far above the cap.
          set_config(1'b1, 16'd32768, 16'd60000, 16'd500, 16'd3000);
        end
        5, 6: begin
          idle_odds = (ph == 5) ? 4 : 2;
          write_reg(CFG_UNUSED, 16'($urandom_range(0, 65535)));
          set_config(1'b1, 16'($urandom_range(0, 65535)), 16'($urandom_range(1, 65535)),
                     16'($urandom_range(0, 5000)), 16'($urandom_range(1, 65535)));
        end
        default: begin
          no_idle = 1'b1;
          set_config(afp_pkg::RST_ADAPT_ENABLE, afp_pkg::RST_ADAPT_FACTOR,
                     afp_pkg::RST_INITIAL_TARGET, afp_pkg::RST_MIN_INTERVAL_MS,
                     afp_pkg::RST_MAX_TARGET);
        end
      endcase
      run_phase(PHASE_ITEMS, (ph == 5) ? PHASE_ITEMS / 2 : 0);
      wait_drained();
    end

    repeat (60) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### adaptive_frame_pacer_core.f
src/afp_pkg.sv
src/adaptive_frame_pacer_core.sv
test/tb.sv
